FILE: rtl/simple9_word_decoder_top_defines.svh
// Assertion macros shared by the decoder's checker.
`ifndef SIMPLE9_WORD_DECODER_TOP_DEFINES_SVH
`define SIMPLE9_WORD_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while reset is asserted
`define S9_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while reset is asserted
`define S9_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/s9_pkg.sv
package s9_pkg;

	// Payload and field sizes
	localparam int PAYLOAD_BITS = 28;
	localparam int SEL_BITS     = 4;
	localparam int WORD_BITS    = PAYLOAD_BITS + SEL_BITS;
	localparam int WIDTH_W      = 5;

	typedef logic [PAYLOAD_BITS-1:0] payload_t;
	typedef logic [SEL_BITS-1:0]     sel_t;
	typedef logic [WIDTH_W-1:0]      width_t;

	// Selector codes that carry a meaning
	localparam sel_t SEL_W1  = 4'd1;
	localparam sel_t SEL_W2  = 4'd2;
	localparam sel_t SEL_W3  = 4'd3;
	localparam sel_t SEL_W4  = 4'd4;
	localparam sel_t SEL_W5  = 4'd5;
	localparam sel_t SEL_W7  = 4'd7;
	localparam sel_t SEL_W9  = 4'd9;
	localparam sel_t SEL_W14 = 4'd14;
	localparam sel_t SEL_W28 = 4'd15;

	typedef enum logic {
		S9_IDLE,
		S9_BUSY
	} s9_state_t;

	// Result of one extraction step
	typedef struct packed {
		payload_t value;
		width_t   unused;
	} field_res_t;

	// Field width per selector; zero marks an unused code
	function automatic width_t width_of_code(input sel_t code);
		width_t w;
		case (code)
			SEL_W1:  w = 5'd1;
			SEL_W2:  w = 5'd2;
			SEL_W3:  w = 5'd3;
			SEL_W4:  w = 5'd4;
			SEL_W5:  w = 5'd5;
			SEL_W7:  w = 5'd7;
			SEL_W9:  w = 5'd9;
			SEL_W14: w = 5'd14;
			SEL_W28: w = 5'd28;
			default: w = 5'd0;
		endcase
		return w;
	endfunction

	// Whole fields in the payload per selector
	function automatic width_t count_of_code(input sel_t code);
		width_t n;
		case (code)
			SEL_W1:  n = 5'(PAYLOAD_BITS / 1);
			SEL_W2:  n = 5'(PAYLOAD_BITS / 2);
			SEL_W3:  n = 5'(PAYLOAD_BITS / 3);
			SEL_W4:  n = 5'(PAYLOAD_BITS / 4);
			SEL_W5:  n = 5'(PAYLOAD_BITS / 5);
			SEL_W7:  n = 5'(PAYLOAD_BITS / 7);
			SEL_W9:  n = 5'(PAYLOAD_BITS / 9);
			SEL_W14: n = 5'(PAYLOAD_BITS / 14);
			SEL_W28: n = 5'(PAYLOAD_BITS / 28);
			default: n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/s9_field_unit.sv
module s9_field_unit (
	input  s9_pkg::payload_t   shift,
	input  s9_pkg::width_t     width,
	output s9_pkg::field_res_t res,
	output s9_pkg::payload_t   shift_next
);
	import s9_pkg::*;

	payload_t mask;
	payload_t v;
	width_t   len;

	// Low field of the remaining payload
	assign mask = ~({PAYLOAD_BITS{1'b1}} << width);
	assign v    = shift & mask;

	// Bit length: position of the highest set bit, plus one
	always_comb begin
		len = '0;
		for (int i = 0; i < PAYLOAD_BITS; i++) begin
			if (v[i]) begin
				len = WIDTH_W'(i + 1);
			end
		end
	end

	assign res.value  = v;
	assign res.unused = width - len;

	// Drop the field just taken
	assign shift_next = shift >> width;

endmodule

FILE: rtl/simple9_word_decoder_top.sv
// Simple-9 word decoder. Each accepted 32-bit word (selector in bits 3..0,
// payload in bits 31..4) is unpacked into floor(28/width) values, lowest
// field first, one value per cycle unless out_stall holds the output,
// each with its count of unused leading bits and with last set on the
// final one. Selectors 1-5, 7, 9 and 14 give that width, 15 gives width
// 28; any other selector gives a single result with bad_selector and last
// set and value zero. One shared field unit (mask, bit-length detect,
// right shift) does one field per cycle while the output is not stalled;
// no new word is taken until the last value of the current one is emitted.
// in_stall is high while a word is being unpacked; a finished value waits in
// the output register while the next one is being prepared.
module simple9_word_decoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [s9_pkg::WORD_BITS-1:0] packed_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [s9_pkg::PAYLOAD_BITS-1:0] value,
	output logic [s9_pkg::WIDTH_W-1:0]  unused_bits,
	output logic                        last,
	output logic                        bad_selector
);
	import s9_pkg::*;

	s9_state_t  state_q, state_d;
	payload_t   shift_q;
	width_t     width_q;
	width_t     left_q;
	logic       bad_q;
	logic       out_valid_q;
	payload_t   value_q;
	width_t     unused_q;
	logic       last_q;
	logic       bad_out_q;

	logic       accept;
	logic       emit;
	sel_t       code;
	width_t     code_width;
	field_res_t res;
	payload_t   shift_next;

	assign code       = packed_word[SEL_BITS-1:0];
	assign code_width = width_of_code(code);

	// Handshake
	assign in_stall = (state_q != S9_IDLE);
	assign accept   = in_valid && !in_stall;
	assign emit     = (state_q == S9_BUSY) && (!out_valid_q || !out_stall);

	s9_field_unit u_field (
		.shift      (shift_q),
		.width      (width_q),
		.res        (res),
		.shift_next (shift_next)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S9_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S9_IDLE: begin
				if (accept) begin
					state_d = S9_BUSY;
				end
			end
			S9_BUSY: begin
				if (emit && left_q == 5'd1) begin
					state_d = S9_IDLE;
				end
			end
			default: state_d = S9_IDLE;
		endcase
	end

	// Word state: remaining payload, width, values still to go
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			width_q <= '0;
			left_q  <= '0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			if (code_width == '0) begin
				shift_q <= '0;
				width_q <= '0;
				left_q  <= 5'd1;
				bad_q   <= 1'b1;
			end else begin
				shift_q <= packed_word[WORD_BITS-1:SEL_BITS];
				width_q <= code_width;
				left_q  <= count_of_code(code);
				bad_q   <= 1'b0;
			end
		end else if (emit) begin
			shift_q <= shift_next;
			left_q  <= left_q - 5'd1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q   <= res.value;
			unused_q  <= res.unused;
			last_q    <= (left_q == 5'd1);
			bad_out_q <= bad_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign unused_bits  = unused_q;
	assign last         = last_q;
	assign bad_selector = bad_out_q;

endmodule

FILE: rtl/s9_checker.sv
`include "simple9_word_decoder_top_defines.svh"

module s9_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [31:0] packed_word,
	input logic        out_valid,
	input logic        out_stall,
	input logic [27:0] value,
	input logic [4:0]  unused_bits,
	input logic        last,
	input logic        bad_selector
);

	// A taken word makes the block busy in the next cycle
	`S9_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after word")

	// A bad selector gives one empty, final result
	`S9_ASSERT_NOW(a_bad_result, out_valid && bad_selector, last && value == 28'd0 && unused_bits == 5'd0, "malformed bad-selector result")

	// Values of one word follow without a gap
	`S9_ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !last, out_valid, "gap inside a word")

	// A stalled result holds
	`S9_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value) && $stable(last), "stalled result changed")

endmodule

bind simple9_word_decoder_top s9_checker u_s9_checker (.*);

FILE: test/simple9_word_decoder_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the decoder, works out the values each accepted
// word should give and compares every accepted value against them in order.
module simple9_word_decoder_checker
	import s9_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [WORD_BITS-1:0]    packed_word,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [PAYLOAD_BITS-1:0] value,
	input  logic [WIDTH_W-1:0]      unused_bits,
	input  logic                    last,
	input  logic                    bad_selector,
	output int                      fail_count,
	output int                      pending,
	output int                      words_seen,
	output int                      values_seen,
	output int                      bad_seen
);

	typedef struct packed {
		payload_t value;
		width_t   unused;
		logic     last;
		logic     bad;
	} unpacked_value_t;

	// values still owed by the decoder, oldest first
	unpacked_value_t owed_values[$];

	// field width for a selector, zero where the code has no meaning
	function automatic width_t selector_width(input sel_t code);
		width_t fw;
		case (code)
			SEL_W1:  fw = 5'd1;
			SEL_W2:  fw = 5'd2;
			SEL_W3:  fw = 5'd3;
			SEL_W4:  fw = 5'd4;
			SEL_W5:  fw = 5'd5;
			SEL_W7:  fw = 5'd7;
			SEL_W9:  fw = 5'd9;
			SEL_W14: fw = 5'd14;
			SEL_W28: fw = 5'd28;
			default: fw = '0;
		endcase
		return fw;
	endfunction

	function automatic width_t significant_bits(input payload_t v);
		width_t n;
		n = '0;
		for (int i = 0; i < PAYLOAD_BITS; i++)
			if (v[i])
				n = width_t'(i + 1);
		return n;
	endfunction

	// split one word into the values it should give, lowest field first
	function automatic void unpack_word(input logic [WORD_BITS-1:0] w);
		width_t          fw;
		payload_t        rest;
		payload_t        mask;
		payload_t        v;
		int              count;
		unpacked_value_t r;
		fw = selector_width(w[SEL_BITS-1:0]);
		if (fw == '0) begin
			r.value  = '0;
			r.unused = '0;
			r.last   = 1'b1;
			r.bad    = 1'b1;
			owed_values.push_back(r);
			return;
		end
		rest  = w[WORD_BITS-1:SEL_BITS];
		mask  = payload_t'((64'd1 << fw) - 64'd1);
		count = PAYLOAD_BITS / int'(fw);
		for (int i = 0; i < count; i++) begin
			v        = rest & mask;
			rest     = rest >> fw;
			r.value  = v;
			r.unused = fw - significant_bits(v);
			r.last   = (i == count - 1);
			r.bad    = 1'b0;
			owed_values.push_back(r);
		end
	endfunction

	// outputs are checked before the new word is unpacked, so a value can
	// never match a word accepted on the same edge
	always @(posedge clk) begin
		unpacked_value_t want;
		int              failed;
		failed = 0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				values_seen <= values_seen + 1;
				if (bad_selector)
					bad_seen <= bad_seen + 1;
				if (owed_values.size() == 0) begin
					failed = 1;
					if (fail_count < 10)
						$display("%0t: unexpected value %h unused %0d last %b bad %b, none owed",
							$realtime, value, unused_bits, last, bad_selector);
				end else begin
					want = owed_values.pop_front();
					if (value !== want.value || unused_bits !== want.unused ||
							last !== want.last || bad_selector !== want.bad) begin
						failed = 1;
						if (fail_count < 10)
							$display("%0t: mismatch, want value %h unused %0d last %b bad %b, got value %h unused %0d last %b bad %b",
								$realtime, want.value, want.unused, want.last, want.bad,
								value, unused_bits, last, bad_selector);
					end
				end
			end
			if (in_valid && !in_stall) begin
				unpack_word(packed_word);
				words_seen <= words_seen + 1;
			end
			fail_count <= fail_count + failed;
			pending    <= owed_values.size();
		end
	end

endmodule

FILE: test/simple9_word_decoder_top_tb.sv
`timescale 1ns / 100ps

module simple9_word_decoder_top_tb;
	import s9_pkg::*;

	localparam int CYCLE_LIMIT      = 600000;
	localparam int TAIL_CYCLES      = 64;
	localparam int WORDS_PER_PHASE  = 144;
	localparam sel_t VALID_SELECTORS [9] = '{SEL_W1, SEL_W2, SEL_W3, SEL_W4, SEL_W5,
		SEL_W7, SEL_W9, SEL_W14, SEL_W28};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    out_stall = 1'b0;
	logic [WORD_BITS-1:0]    packed_word = '0;
	logic                    in_stall;
	logic                    out_valid;
	logic [PAYLOAD_BITS-1:0] value;
	logic [WIDTH_W-1:0]      unused_bits;
	logic                    last;
	logic                    bad_selector;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int cycles = 0;
	int fail_count;
	int pending;
	int words_seen;
	int values_seen;
	int bad_seen;

	simple9_word_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.packed_word  (packed_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.unused_bits  (unused_bits),
		.last         (last),
		.bad_selector (bad_selector)
	);

	simple9_word_decoder_checker value_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.packed_word  (packed_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.unused_bits  (unused_bits),
		.last         (last),
		.bad_selector (bad_selector),
		.fail_count   (fail_count),
		.pending      (pending),
		.words_seen   (words_seen),
		.values_seen  (values_seen),
		.bad_seen     (bad_seen)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simple9_word_decoder_top_tb failed");
			$finish;
		end
	end

	// offer one word, with random idle cycles first, and hold it until taken
	task automatic send_word(input logic [WORD_BITS-1:0] w);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		packed_word <= w;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending until every owed value has come out
	task automatic wait_all_values();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// mostly meaningful selectors; payloads dense, sparse, short or all ones
	function automatic logic [WORD_BITS-1:0] random_word();
		sel_t     code;
		payload_t data;
		bit       meaningful;
		if ($urandom_range(99) < 85) begin
			code = VALID_SELECTORS[$urandom_range(8)];
		end else begin
			do begin
				code = sel_t'($urandom());
				meaningful = 1'b0;
				foreach (VALID_SELECTORS[i])
					if (VALID_SELECTORS[i] == code)
						meaningful = 1'b1;
			end while (meaningful);
		end
		case ($urandom_range(3))
			0:       data = payload_t'($urandom());
			1:       data = payload_t'($urandom() & $urandom() & $urandom());
			2:       data = payload_t'($urandom() >> $urandom_range(31));
			default: data = '1;
		endcase
		return {data, code};
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words under the first idling mix
		tx_idle_pct  = 6;
		rx_idle_pct <= 85;
		for (int c = 0; c < (1 << SEL_BITS); c++)
			send_word({{PAYLOAD_BITS{1'b1}}, sel_t'(c)});
		send_word('0);
		send_word({payload_t'(0), SEL_W1});
		send_word({payload_t'(0), SEL_W28});
		// bits above the last whole field must be dropped
		send_word({28'hE000000, SEL_W5});
		send_word({28'h8000000, SEL_W3});
		send_word({28'h8000000, SEL_W9});
		send_word({28'h0000001, SEL_W28});
		send_word({payload_t'($urandom()), SEL_W14});
		send_word({payload_t'($urandom()), SEL_W2});
		wait_all_values();

		// random words: sender eager / receiver slow, swapped, then flat out
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct  = 6;
					rx_idle_pct <= 85;
				end
				1: begin
					tx_idle_pct  = 85;
					rx_idle_pct <= 6;
				end
				default: begin
					tx_idle_pct  = 0;
					rx_idle_pct <= 0;
				end
			endcase
			repeat (WORDS_PER_PHASE)
				send_word(random_word());
			wait_all_values();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d words unpacked into %0d values (%0d unused selectors), "
			, words_seen, values_seen, bad_seen,
			"under three sender/receiver idling mixes");
		if (fail_count == 0 && pending == 0)
			$display("simple9_word_decoder_top_tb passed");
		else begin
			$display("%0d mismatches, %0d values still owed", fail_count, pending);
			$display("simple9_word_decoder_top_tb failed");
		end
		$finish;
	end

endmodule
